>>> sv/hbi_pkg.sv
// Shared widths, coefficients and queue entry type for the half-band 2x interpolator.
package hbi_pkg;

  localparam int SAMPLE_W = 24;
  localparam int TAPS     = 7;
  localparam int COEF_W   = 18;   // fractional bits of the coefficients
  localparam int SUM_W    = SAMPLE_W + 1;
  localparam int PROD_W   = SUM_W + COEF_W + 1;
  localparam int RND_W    = PROD_W - COEF_W;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  // Coefficients, unsigned Q0.18, held with one extra bit so they multiply as signed.
  localparam logic signed [COEF_W:0] COEF0 = (COEF_W + 1)'(161143);
  localparam logic signed [COEF_W:0] COEF1 = (COEF_W + 1)'(40220);
  localparam logic signed [COEF_W:0] COEF2 = (COEF_W + 1)'(12739);
  localparam logic signed [COEF_W:0] COEF3 = (COEF_W + 1)'(2711);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic signed [PROD_W-1:0]   prod_t;

  // One classified item: the pass-through sample and the four symmetric pair sums.
  typedef struct packed {
    sample_t delayed;
    sum_t    sum0;
    sum_t    sum1;
    sum_t    sum2;
    sum_t    sum3;
  } hbi_entry_t;

  // Queue status seen by the front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } hbi_qstat_t;

endpackage

>>> sv/hbi_front.sv
// Front end: accepts input samples, keeps the delay line and forms the pair sums.
module hbi_front import hbi_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  sample_t    sample_in_i,
  input  hbi_qstat_t qstat_i,
  output logic       push_o,
  output hbi_entry_t entry_o
);

  sample_t dly_q [TAPS];
  logic    accept;

  assign in_stall_o = qstat_i.full;
  assign accept     = in_valid_i && !qstat_i.full;
  assign push_o     = accept;

  always_comb begin
    entry_o.delayed = dly_q[2];
    entry_o.sum0    = SUM_W'(dly_q[2]) + SUM_W'(dly_q[3]);
    entry_o.sum1    = SUM_W'(dly_q[1]) + SUM_W'(dly_q[4]);
    entry_o.sum2    = SUM_W'(dly_q[0]) + SUM_W'(dly_q[5]);
    entry_o.sum3    = SUM_W'(sample_in_i) + SUM_W'(dly_q[6]);
  end

  // Shift the delay line on every transfer; newest sample enters at tap 0.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS; i++) dly_q[i] <= '0;
    end else if (accept) begin
      dly_q[0] <= sample_in_i;
      for (int i = 1; i < TAPS; i++) dly_q[i] <= dly_q[i-1];
    end
  end

endmodule

>>> sv/hbi_queue.sv
// Two-entry queue between the front end and the back end.
module hbi_queue import hbi_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  hbi_entry_t wdata_i,
  input  logic       pop_i,
  output hbi_entry_t rdata_o,
  output hbi_qstat_t qstat_o
);

  hbi_entry_t              mem [QDEPTH];
  logic [QPTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]       cnt_q;

  assign qstat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign qstat_o.empty = (cnt_q == '0);
  assign rdata_o       = mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem[wr_ptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat_o.full |-> !push_i || pop_i)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat_o.empty |-> !pop_i)
    else $error("pop from empty queue");

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i && cnt_q == QCNT_W'(QDEPTH - 1)) |=> qstat_o.full)
    else $error("queue count lost an entry");

endmodule

>>> sv/hbi_back.sv
// Back end: multiplies, accumulates, rounds and saturates, and emits the output pair.
module hbi_back import hbi_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  hbi_entry_t entry_i,
  input  hbi_qstat_t qstat_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output sample_t    sample_out_o,
  output logic       last_of_pair_o
);

  // Operand stage: one entry being emitted as two results.
  logic    op_valid_q, op_valid_d;
  logic    phase_q, phase_d;
  sample_t op_delayed_q;
  prod_t   p0_q, p1_q, p2_q, p3_q;
  prod_t   acc_q;

  logic    out_valid_q, out_valid_d;
  sample_t out_sample_q, out_sample_d;
  logic    out_last_q, out_last_d;

  logic                 out_free, emit;
  logic signed [RND_W-1:0] rnd;
  sample_t              sat;

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = op_valid_q && out_free;
  assign pop_o    = !qstat_i.empty && (!op_valid_q || (emit && phase_q));

  // Round to nearest (ties up), then clamp to the sample range.
  always_comb begin
    rnd = RND_W'((acc_q + (PROD_W'(1) <<< (COEF_W - 1))) >>> COEF_W);
    if (rnd[RND_W-1:SAMPLE_W-1] == '0 || rnd[RND_W-1:SAMPLE_W-1] == '1) begin
      sat = rnd[SAMPLE_W-1:0];
    end else begin
      sat = {rnd[RND_W-1], {(SAMPLE_W-1){~rnd[RND_W-1]}}};
    end
  end

  always_comb begin
    op_valid_d   = op_valid_q;
    phase_d      = phase_q;
    out_valid_d  = out_valid_q;
    out_sample_d = out_sample_q;
    out_last_d   = out_last_q;
    if (emit) begin
      out_valid_d  = 1'b1;
      out_sample_d = phase_q ? sat : op_delayed_q;
      out_last_d   = phase_q;
      if (phase_q) begin
        op_valid_d = 1'b0;
        phase_d    = 1'b0;
      end else begin
        phase_d = 1'b1;
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (pop_o) begin
      op_valid_d = 1'b1;
      phase_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q  <= 1'b0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      op_valid_q  <= op_valid_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      op_delayed_q <= entry_i.delayed;
      p0_q         <= entry_i.sum0 * COEF0;
      p1_q         <= entry_i.sum1 * COEF1;
      p2_q         <= entry_i.sum2 * COEF2;
      p3_q         <= entry_i.sum3 * COEF3;
    end
    // Products hold while the entry is live; the sum settles before the midpoint is due.
    acc_q        <= p0_q - p1_q + p2_q - p3_q;
    out_sample_q <= out_sample_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign sample_out_o   = out_sample_q;
  assign last_of_pair_o = out_last_q;

  a_phase_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> op_valid_q)
    else $error("second phase without a live entry");

  a_mid_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && phase_q) |=> !phase_q)
    else $error("entry not released after midpoint");

  a_no_early_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_valid_q && !phase_q) |-> !pop_o)
    else $error("entry replaced before both results left");

endmodule

>>> sv/halfband_fir_interpolate_2x_core.sv
// Top level of the 2x half-band FIR interpolator.
//
// Input channel: in_valid_i / in_stall_o with sample_in_i, a signed 24-bit sample.
// A transfer happens at a rising edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i with sample_out_o and last_of_pair_o.
// Every input sample produces two transfers, in order: first the sample
// delayed by three input periods (last_of_pair_o low), then the filtered
// midpoint, rounded to nearest and saturated (last_of_pair_o high).
// The delayed sample passes through the queue, the operand stage and the output
// register; the midpoint follows it there as soon as the receiver does not stall.
// Samples are taken while a pair is still being emitted, if the queue has room;
// the single output register that carries both results of a pair sets the pace.
// The front end keeps the seven-tap delay line and forms the pair sums; a
// two-entry queue decouples it from the back end, which multiplies, adds,
// rounds and emits. A stalled receiver holds the output register; the queue
// then fills and in_stall_o rises, so nothing is dropped.
// Reset (asynchronous, active low) clears the delay line to zero and empties
// the queue and the output register.
module halfband_fir_interpolate_2x_core import hbi_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  sample_t sample_in_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output sample_t sample_out_o,
  output logic    last_of_pair_o
);

  hbi_qstat_t qstat;
  hbi_entry_t push_entry, pop_entry;
  logic       push, pop;

  // Accept samples, advance the delay line, classify into pair sums.
  hbi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_in_i (sample_in_i),
    .qstat_i     (qstat),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  // Hold up to two classified items between the two halves.
  hbi_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .pop_i   (pop),
    .rdata_o (pop_entry),
    .qstat_o (qstat)
  );

  // Compute the midpoint and emit both results of each pair.
  hbi_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .entry_i        (pop_entry),
    .qstat_i        (qstat),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sample_out_o   (sample_out_o),
    .last_of_pair_o (last_of_pair_o)
  );

endmodule
